// ===== design/rtlw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rtlw_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int POS_BITS   = 15;
    localparam int COUNT_BITS = 32;
    localparam int NUM_DIRS   = 4;
    localparam int THRESH_W   = 64;
    localparam int CFG_IDX_W  = 3;

    // thirds of the unit interval, rounded up
    localparam logic [63:0] ONE_THIRD_W  = ((64'd1 << FRAC_BITS) + 64'd2) / 64'd3;
    localparam logic [63:0] TWO_THIRDS_W = ((64'd1 << (FRAC_BITS + 1)) + 64'd2) / 64'd3;
    localparam logic [FRAC_BITS-1:0] ONE_THIRD  = ONE_THIRD_W[FRAC_BITS-1:0];
    localparam logic [FRAC_BITS-1:0] TWO_THIRDS = TWO_THIRDS_W[FRAC_BITS-1:0];

    typedef logic [FRAC_BITS-1:0]         frac_t;
    typedef logic [POS_BITS-1:0]          pos_t;
    typedef logic [1:0]                   dir_t;
    typedef logic signed [COUNT_BITS-1:0] count_t;
    typedef logic [THRESH_W-1:0]          thresh_t;

    localparam count_t COUNT_MAX = {1'b0, {(COUNT_BITS - 1){1'b1}}};
    localparam count_t COUNT_MIN = {1'b1, {(COUNT_BITS - 1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_THRESH0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd6;

    localparam pos_t RESET_WIDTH  = POS_BITS'(10);
    localparam pos_t RESET_HEIGHT = POS_BITS'(10);

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_PLACE,
        CMD_SETDIR,
        CMD_NOP
    } cmd_t;

    typedef enum logic [2:0] {
        MV_PX,
        MV_MX,
        MV_PY,
        MV_MY,
        MV_NONE
    } move_t;

    // one classified request, waiting for the back end
    typedef struct packed {
        cmd_t                     cmd;
        logic                     flip;
        dir_t                     pick;
        move_t [NUM_DIRS-1:0]     moves;
        pos_t                     start_x;
        pos_t                     start_y;
        dir_t                     start_dir;
    } task_t;

endpackage
`default_nettype wire

// ===== design/rtlw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtlw_front (
    input  wire logic [1:0]                    command,
    input  wire rtlw_pkg::frac_t               rand_flip,
    input  wire rtlw_pkg::frac_t               rand_pick,
    input  wire rtlw_pkg::frac_t               rand_move,
    input  wire rtlw_pkg::pos_t                start_x,
    input  wire rtlw_pkg::pos_t                start_y,
    input  wire rtlw_pkg::dir_t                start_direction,
    input  wire rtlw_pkg::thresh_t             cum_thresh [rtlw_pkg::NUM_DIRS],
    input  wire rtlw_pkg::frac_t               flip_threshold,
    output rtlw_pkg::task_t                    task_out
);
    import rtlw_pkg::*;

    move_t [NUM_DIRS-1:0] moves;

    // first field that rand_move falls below, for every direction
    always_comb
    begin
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            moves[d] = MV_NONE;
            for (int i = NUM_DIRS - 1; i >= 0; i--)
            begin
                if (rand_move < cum_thresh[d][i*FRAC_BITS +: FRAC_BITS])
                begin
                    moves[d] = move_t'(3'(i));
                end
            end
        end
    end

    always_comb
    begin
        task_out.cmd       = cmd_t'(command);
        task_out.flip      = (rand_flip <= flip_threshold);
        if (rand_pick < ONE_THIRD)
        begin
            task_out.pick = 2'd0;
        end
        else if (rand_pick < TWO_THIRDS)
        begin
            task_out.pick = 2'd1;
        end
        else
        begin
            task_out.pick = 2'd2;
        end
        task_out.moves     = moves;
        task_out.start_x   = start_x;
        task_out.start_y   = start_y;
        task_out.start_dir = start_direction;
    end

endmodule
`default_nettype wire

// ===== design/rtlw_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtlw_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire rtlw_pkg::task_t  item_in,
    input  wire logic             pop,
    output rtlw_pkg::task_t       head,
    output logic                  empty,
    output logic                  full
);
    import rtlw_pkg::*;

    task_t       slots_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/rtlw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtlw_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rtlw_pkg::task_t  head,
    input  wire logic             empty,
    output logic                  pop,
    input  wire rtlw_pkg::pos_t   width_x,
    input  wire rtlw_pkg::pos_t   height_y,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output rtlw_pkg::pos_t        walker_x,
    output rtlw_pkg::pos_t        walker_y,
    output rtlw_pkg::dir_t        walker_direction,
    output rtlw_pkg::count_t      net_crossings
);
    import rtlw_pkg::*;

    pos_t    pos_x_reg;
    pos_t    pos_x_next;
    pos_t    pos_y_reg;
    pos_t    pos_y_next;
    dir_t    dir_reg;
    dir_t    dir_next;
    count_t  count_reg;
    count_t  count_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    dir_t    tick_dir;
    move_t   move;

    // state doubles as the output register: it only changes when a result is loaded
    assign pop              = !empty && (!out_valid_reg || !out_stall);
    assign out_valid        = out_valid_reg;
    assign walker_x         = pos_x_reg;
    assign walker_y         = pos_y_reg;
    assign walker_direction = dir_reg;
    assign net_crossings    = count_reg;

    always_comb
    begin
        if (head.flip)
        begin
            tick_dir = (head.pick < dir_reg) ? head.pick : head.pick + 2'd1;
        end
        else
        begin
            tick_dir = dir_reg;
        end
        move = head.moves[tick_dir];
    end

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        dir_next   = dir_reg;
        count_next = count_reg;
        unique case (head.cmd)
            CMD_TICK:
            begin
                dir_next = tick_dir;
                case (move)
                    MV_PX:
                    begin
                        if (pos_x_reg >= width_x)
                        begin
                            // wrap past the right edge
                            pos_x_next = POS_BITS'(1);
                            if (count_reg != COUNT_MAX)
                            begin
                                count_next = count_reg + COUNT_BITS'(1);
                            end
                        end
                        else
                        begin
                            pos_x_next = pos_x_reg + POS_BITS'(1);
                        end
                    end
                    MV_MX:
                    begin
                        if (pos_x_reg == '0)
                        begin
                            pos_x_next = (width_x == '0) ? '0 : width_x - POS_BITS'(1);
                            if (count_reg != COUNT_MIN)
                            begin
                                count_next = count_reg - COUNT_BITS'(1);
                            end
                        end
                        else
                        begin
                            pos_x_next = pos_x_reg - POS_BITS'(1);
                        end
                    end
                    MV_PY:
                    begin
                        pos_y_next = (pos_y_reg >= height_y) ? height_y
                                                             : pos_y_reg + POS_BITS'(1);
                    end
                    MV_MY:
                    begin
                        if (pos_y_reg != '0)
                        begin
                            pos_y_next = pos_y_reg - POS_BITS'(1);
                        end
                    end
                    default:
                    begin
                        pos_x_next = pos_x_reg;
                    end
                endcase
            end
            CMD_PLACE:
            begin
                pos_x_next = head.start_x;
                pos_y_next = head.start_y;
            end
            CMD_SETDIR:
            begin
                dir_next   = head.start_dir;
                count_next = '0;
            end
            CMD_NOP:
            begin
                dir_next = dir_reg;
            end
        endcase
    end

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            dir_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
                dir_reg   <= dir_next;
                count_reg <= count_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/run_tumble_lattice_walker.sv =====
// Run-and-tumble lattice walker, one step per request.
// Input channel: in_valid/in_stall with command, three 0.16 random numbers
// and the place/set-direction operands. A request is taken when in_valid is
// high and in_stall is low. Every request yields exactly one result.
// Output channel: out_valid/out_stall with walker_x, walker_y,
// walker_direction and net_crossings, the state after that step.
// Configuration: cfg_valid/cfg_ready with cfg_index (0..3 thresholds per
// direction, 4 flip threshold, 5 width, 6 height) and cfg_data; cfg_ready is
// always high. Write only while no request is in flight.
// Results: a taken request is written into the queue, and the back end then
// loads its step into the walker state, which is the output register.
// Throughput: one request per cycle while out_stall is low; the front end
// classifies a request in its accept cycle, a two-entry queue holds it, and
// the back end updates the walker state, the output register, as it pops it.
// When out_stall is high the result holds and the queue fills; in_stall
// rises once both queue entries are occupied.
// Reset clears position, direction, count and queue; thresholds reset to 0,
// width and height to 10.
`timescale 1ns / 1ps
`default_nettype none
module run_tumble_lattice_walker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   command,
    input  wire rtlw_pkg::frac_t              rand_flip,
    input  wire rtlw_pkg::frac_t              rand_pick,
    input  wire rtlw_pkg::frac_t              rand_move,
    input  wire rtlw_pkg::pos_t               start_x,
    input  wire rtlw_pkg::pos_t               start_y,
    input  wire rtlw_pkg::dir_t               start_direction,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output rtlw_pkg::pos_t                    walker_x,
    output rtlw_pkg::pos_t                    walker_y,
    output rtlw_pkg::dir_t                    walker_direction,
    output rtlw_pkg::count_t                  net_crossings,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [rtlw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire rtlw_pkg::thresh_t            cfg_data
);
    import rtlw_pkg::*;

    thresh_t  cum_thresh_reg [NUM_DIRS];
    frac_t    flip_threshold_reg;
    pos_t     width_x_reg;
    pos_t     height_y_reg;
    task_t    front_task;
    task_t    head;
    logic     push;
    logic     pop;
    logic     empty;
    logic     full;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign push      = in_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < NUM_DIRS; d++)
            begin
                cum_thresh_reg[d] <= '0;
            end
            flip_threshold_reg <= '0;
            width_x_reg        <= RESET_WIDTH;
            height_y_reg       <= RESET_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_THRESH0: cum_thresh_reg[0] <= cfg_data;
                REG_THRESH1: cum_thresh_reg[1] <= cfg_data;
                REG_THRESH2: cum_thresh_reg[2] <= cfg_data;
                REG_THRESH3: cum_thresh_reg[3] <= cfg_data;
                REG_FLIP:    flip_threshold_reg <= cfg_data[FRAC_BITS-1:0];
                REG_WIDTH:   width_x_reg <= cfg_data[POS_BITS-1:0];
                REG_HEIGHT:  height_y_reg <= cfg_data[POS_BITS-1:0];
                default:     flip_threshold_reg <= flip_threshold_reg;
            endcase
        end
    end

    rtlw_front u_front (
        .command         (command),
        .rand_flip       (rand_flip),
        .rand_pick       (rand_pick),
        .rand_move       (rand_move),
        .start_x         (start_x),
        .start_y         (start_y),
        .start_direction (start_direction),
        .cum_thresh      (cum_thresh_reg),
        .flip_threshold  (flip_threshold_reg),
        .task_out        (front_task)
    );

    rtlw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item_in (front_task),
        .pop     (pop),
        .head    (head),
        .empty   (empty),
        .full    (full)
    );

    rtlw_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .empty            (empty),
        .pop              (pop),
        .width_x          (width_x_reg),
        .height_y         (height_y_reg),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .walker_x         (walker_x),
        .walker_y         (walker_y),
        .walker_direction (walker_direction),
        .net_crossings    (net_crossings)
    );

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import rtlw_pkg::*;

    // tumble picks split the unit interval at thirds, rounded up
    localparam frac_t PICK_ONE = frac_t'(((1 << FRAC_BITS) + 2) / 3);
    localparam frac_t PICK_TWO = frac_t'(((1 << (FRAC_BITS + 1)) + 2) / 3);
    localparam int LONG_HOLD = 48;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 125;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        cmd_t  cmd;
        frac_t rflip;
        frac_t rpick;
        frac_t rmove;
        pos_t  sx;
        pos_t  sy;
        dir_t  sd;
    } walker_req_t;

    typedef struct packed {
        pos_t   x;
        pos_t   y;
        dir_t   dir;
        count_t crossings;
    } walker_state_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           command;
    frac_t                rand_flip;
    frac_t                rand_pick;
    frac_t                rand_move;
    pos_t                 start_x;
    pos_t                 start_y;
    dir_t                 start_direction;
    logic                 out_valid;
    logic                 out_stall;
    pos_t                 walker_x;
    pos_t                 walker_y;
    dir_t                 walker_direction;
    count_t               net_crossings;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    thresh_t              cfg_data;

    // lattice settings and walker state as the block should hold them
    thresh_t lat_thresh [NUM_DIRS];
    frac_t   lat_flip;
    pos_t    lat_width;
    pos_t    lat_height;
    pos_t    wk_x;
    pos_t    wk_y;
    dir_t    wk_dir;
    count_t  wk_crossings;

    walker_state_t pending_steps [$];
    int unsigned   mismatch_count = 0;
    bit            gaps_on = 1'b1;
    bit            stalls_on = 1'b1;
    bit            long_hold_req = 1'b0;

    run_tumble_lattice_walker u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .rand_flip        (rand_flip),
        .rand_pick        (rand_pick),
        .rand_move        (rand_move),
        .start_x          (start_x),
        .start_y          (start_y),
        .start_direction  (start_direction),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .walker_x         (walker_x),
        .walker_y         (walker_y),
        .walker_direction (walker_direction),
        .net_crossings    (net_crossings),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // mostly short idles, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void bump_crossings(bit up);
        if (up)
        begin
            if (wk_crossings != COUNT_MAX)
                wk_crossings = wk_crossings + 1;
        end
        else if (wk_crossings != COUNT_MIN)
        begin
            wk_crossings = wk_crossings - 1;
        end
    endfunction

    function automatic void walker_tick(frac_t rf, frac_t rp, frac_t rm);
        int unsigned pick;
        move_t       mv;
        mv = MV_NONE;
        if (rf <= lat_flip)
        begin
            pick = (rp < PICK_ONE) ? 0 : (rp < PICK_TWO) ? 1 : 2;
            // skip over the current direction
            wk_dir = (pick < wk_dir) ? dir_t'(pick) : dir_t'(pick + 1);
        end
        // scan from the last field so the first hit in order wins
        for (int i = NUM_DIRS - 1; i >= 0; i--)
            if (rm < lat_thresh[wk_dir][i * FRAC_BITS +: FRAC_BITS])
                mv = move_t'(i);
        case (mv)
            MV_PX:
            begin
                if (wk_x >= lat_width)
                begin
                    wk_x = pos_t'(1);
                    bump_crossings(1'b1);
                end
                else
                begin
                    wk_x = wk_x + 1'b1;
                end
            end
            MV_MX:
            begin
                if (wk_x == '0)
                begin
                    wk_x = (lat_width == '0) ? '0 : lat_width - 1'b1;
                    bump_crossings(1'b0);
                end
                else
                begin
                    wk_x = wk_x - 1'b1;
                end
            end
            MV_PY: wk_y = (wk_y >= lat_height) ? lat_height : wk_y + 1'b1;
            MV_MY:
            begin
                if (wk_y != '0)
                    wk_y = wk_y - 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic walker_state_t advance_walker(walker_req_t rq);
        case (rq.cmd)
            CMD_TICK: walker_tick(rq.rflip, rq.rpick, rq.rmove);
            CMD_PLACE:
            begin
                wk_x = rq.sx;
                wk_y = rq.sy;
            end
            CMD_SETDIR:
            begin
                wk_dir = rq.sd;
                wk_crossings = '0;
            end
            default: ;
        endcase
        return '{x: wk_x, y: wk_y, dir: wk_dir, crossings: wk_crossings};
    endfunction

    // unused operand fields carry noise
    function automatic walker_req_t cmd_req(cmd_t c);
        walker_req_t rq;
        rq.cmd   = c;
        rq.rflip = frac_t'($urandom);
        rq.rpick = frac_t'($urandom);
        rq.rmove = frac_t'($urandom);
        rq.sx    = pos_t'($urandom);
        rq.sy    = pos_t'($urandom);
        rq.sd    = dir_t'($urandom);
        return rq;
    endfunction

    function automatic walker_req_t tick_req(frac_t rf, frac_t rp, frac_t rm);
        walker_req_t rq;
        rq = cmd_req(CMD_TICK);
        rq.rflip = rf;
        rq.rpick = rp;
        rq.rmove = rm;
        return rq;
    endfunction

    function automatic walker_req_t place_req(pos_t px, pos_t py);
        walker_req_t rq;
        rq = cmd_req(CMD_PLACE);
        rq.sx = px;
        rq.sy = py;
        return rq;
    endfunction

    function automatic walker_req_t setdir_req(dir_t d);
        walker_req_t rq;
        rq = cmd_req(CMD_SETDIR);
        rq.sd = d;
        return rq;
    endfunction

    // positions cluster around the walls so wraps and clamps happen often
    function automatic pos_t near_bound(pos_t lim);
        int v;
        case ($urandom_range(0, 3))
            0: v = int'($urandom_range(0, (1 << POS_BITS) - 1));
            1: v = int'($urandom_range(0, 3));
            default: v = int'(lim) + 1 - int'($urandom_range(0, 3));
        endcase
        if (v < 0)
            v = 0;
        return pos_t'(v);
    endfunction

    function automatic walker_req_t random_request();
        int unsigned r;
        frac_t       rf;
        r = $urandom_range(0, 99);
        rf = ($urandom_range(0, 7) == 0) ? lat_flip : frac_t'($urandom);
        if (r < 76)
            return tick_req(rf, frac_t'($urandom), frac_t'($urandom));
        if (r < 88)
            return place_req(near_bound(lat_width), near_bound(lat_height));
        if (r < 96)
            return setdir_req(dir_t'($urandom));
        return cmd_req(CMD_NOP);
    endfunction

    // mostly ascending cumulative fields, sometimes arbitrary order
    function automatic thresh_t random_thresholds();
        frac_t lv [$];
        if ($urandom_range(0, 3) == 0)
            return {$urandom, $urandom};
        repeat (NUM_DIRS) lv.push_back(frac_t'($urandom));
        lv.sort();
        return {lv[3], lv[2], lv[1], lv[0]};
    endfunction

    task automatic send_request(input walker_req_t rq);
        int unsigned gap;
        gap = gaps_on ? idle_len() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        command         <= rq.cmd;
        rand_flip       <= rq.rflip;
        rand_pick       <= rq.rpick;
        rand_move       <= rq.rmove;
        start_x         <= rq.sx;
        start_y         <= rq.sy;
        start_direction <= rq.sd;
        do @(posedge clk); while (in_stall);
        pending_steps.push_back(advance_walker(rq));
    endtask

    // hold off new requests until every result is back
    task automatic settle_walker();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_steps.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input thresh_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_THRESH0, REG_THRESH1, REG_THRESH2, REG_THRESH3:
                lat_thresh[idx - REG_THRESH0] = data;
            REG_FLIP:   lat_flip = data[FRAC_BITS-1:0];
            REG_WIDTH:  lat_width = data[POS_BITS-1:0];
            REG_HEIGHT: lat_height = data[POS_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic load_lattice(input thresh_t [NUM_DIRS-1:0] th, input frac_t flip,
                                input pos_t w, input pos_t h, input bit thresholds_only);
        for (int d = 0; d < NUM_DIRS; d++)
            write_reg(CFG_IDX_W'(REG_THRESH0 + d), th[d]);
        if (!thresholds_only)
        begin
            write_reg(REG_FLIP, thresh_t'(flip));
            write_reg(REG_WIDTH, thresh_t'(w));
            write_reg(REG_HEIGHT, thresh_t'(h));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        thresh_t [NUM_DIRS-1:0] th;
        // flip threshold resets to zero: only a zero flip number tumbles
        send_request(tick_req(16'd1, 16'd0, 16'd0));
        send_request(tick_req(16'd0, 16'd0, 16'hFFFF));
        send_request(place_req(pos_t'('1), pos_t'('1)));
        send_request(cmd_req(CMD_NOP));
        send_request(setdir_req(dir_t'(0)));
        send_request(place_req(pos_t'(9), pos_t'(3)));
        settle_walker();
        // +x only, against the reset width
        th = '0;
        th[0] = thresh_t'(16'hFFFF);
        load_lattice(th, '0, '0, '0, 1'b1);
        send_request(tick_req(16'hFFFF, frac_t'($urandom), 16'd0));
        send_request(tick_req(16'hFFFF, frac_t'($urandom), 16'd0));
    endtask

    task automatic test_tumble_choice();
        thresh_t [NUM_DIRS-1:0] th;
        frac_t picks [6];
        picks = '{16'd0, PICK_ONE - 1'b1, PICK_ONE, PICK_TWO - 1'b1, PICK_TWO, 16'hFFFF};
        settle_walker();
        th = '0;
        load_lattice(th, 16'h8000, pos_t'(1), pos_t'(1), 1'b0);
        send_request(tick_req(16'h8001, 16'd0, frac_t'($urandom)));
        foreach (picks[i])
            send_request(tick_req(16'h8000, picks[i], frac_t'($urandom)));
    endtask

    task automatic test_wall_and_wrap();
        thresh_t [NUM_DIRS-1:0] th;
        settle_walker();
        th[0] = 64'h0000_FFFF_0100_8000;    // fields out of order
        th[1] = 64'h0000_0000_FFFF_0000;
        th[2] = 64'h0000_FFFF_0000_0000;
        th[3] = 64'hFFFF_0000_0000_0000;
        load_lattice(th, '0, pos_t'('1), pos_t'(1), 1'b0);
        send_request(setdir_req(dir_t'(0)));
        send_request(place_req(pos_t'('1), pos_t'(0)));
        send_request(tick_req(16'hFFFF, frac_t'($urandom), 16'h0050));
        send_request(tick_req(16'hFFFF, frac_t'($urandom), 16'h9000));
        send_request(tick_req(16'hFFFF, frac_t'($urandom), 16'h9000));
        send_request(tick_req(16'hFFFF, frac_t'($urandom), 16'hFFFF));
        send_request(setdir_req(dir_t'(1)));
        send_request(place_req(pos_t'(0), pos_t'('1)));
        send_request(tick_req(16'hFFFF, frac_t'($urandom), 16'd0));
        send_request(setdir_req(dir_t'(3)));
        send_request(place_req(pos_t'(0), pos_t'(0)));
        send_request(tick_req(16'hFFFF, frac_t'($urandom), 16'd0));
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        long_hold_req = 1'b1;
        repeat (16) send_request(random_request());
        settle_walker();
        repeat (8) send_request(random_request());
        gaps_on = 1'b1;
    endtask

    task automatic test_random_walks();
        thresh_t [NUM_DIRS-1:0] th;
        frac_t                  flip;
        pos_t                   w;
        pos_t                   h;
        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            for (int d = 0; d < NUM_DIRS; d++)
                th[d] = random_thresholds();
            flip = ($urandom_range(0, 1) != 0) ? frac_t'($urandom_range(0, 16'h3000))
                                               : frac_t'($urandom);
            w = pos_t'($urandom_range(1, 12));
            h = pos_t'($urandom_range(1, 12));
            case (k)
                0:
                begin
                    flip = '0;
                    w = pos_t'(1);
                    h = pos_t'('1);
                end
                1:
                begin
                    flip = '1;
                    w = pos_t'('1);
                    h = pos_t'(1);
                end
                2:
                begin
                    w = pos_t'(2);
                    h = pos_t'(2);
                end
                6:
                begin
                    w = pos_t'($urandom_range(1, (1 << POS_BITS) - 1));
                    h = pos_t'($urandom_range(1, (1 << POS_BITS) - 1));
                end
                default: ;
            endcase
            settle_walker();
            load_lattice(th, flip, w, h, 1'b0);
            gaps_on = (k % 3) != 2;
            stalls_on = (k % 4) != 1;
            repeat (PHASE_ITEMS) send_request(random_request());
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    // result side hold-offs
    initial
    begin : drive_out_stall
        int unsigned stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (stalls_on)
                    stall_left = idle_len();
            end
        end
    end

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        walker_state_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_steps.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unrequested result, expected none actual x=%0d y=%0d",
                             $time, walker_x, walker_y);
            end
            else
            begin
                want = pending_steps.pop_front();
                check_field("walker_x", want.x, walker_x);
                check_field("walker_y", want.y, walker_y);
                check_field("walker_direction", want.dir, walker_direction);
                check_field("net_crossings", $signed(want.crossings), net_crossings);
            end
        end
    end

    initial
    begin
        for (int d = 0; d < NUM_DIRS; d++)
            lat_thresh[d] = '0;
        lat_flip     = '0;
        lat_width    = pos_t'(10);
        lat_height   = pos_t'(10);
        wk_x         = '0;
        wk_y         = '0;
        wk_dir       = '0;
        wk_crossings = '0;
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        command         <= CMD_TICK;
        rand_flip       <= '0;
        rand_pick       <= '0;
        rand_move       <= '0;
        start_x         <= '0;
        start_y         <= '0;
        start_direction <= '0;
        cfg_valid       <= 1'b0;
        cfg_index       <= REG_THRESH0;
        cfg_data        <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_tumble_choice();
        test_wall_and_wrap();
        test_backpressure();
        test_random_walks();

        settle_walker();
        // keep watching the outputs for stray results
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_steps.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/rtlw_pkg.sv
design/rtlw_front.sv
design/rtlw_queue.sv
design/rtlw_back.sv
design/run_tumble_lattice_walker.sv
dv/testbench.sv
